### rtl/jet_pkg.sv
// Shared types, constants and helpers for the Julia escape-time block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package jet_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 12;
  localparam int WORD_W     = 32;
  localparam int STEP_W     = 31;
  localparam int CONST_W    = 30;
  localparam int ITER_W     = 16;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OFFS_W     = COORD_BITS + STEP_W;

  // Point queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Escape test: re^2 + im^2 >= 4.0 at double fraction width
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

  localparam logic signed [PROD_W-1:0] WORD_MAX_W = PROD_W'((64'sd1 <<< (WORD_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] WORD_MIN_W = -(PROD_W'(64'sd1 <<< (WORD_W - 1)));

  // Reset values of the configuration registers
  localparam logic signed [WORD_W-1:0]  RST_ORIGIN_RE = -32'sd536870912;
  localparam logic signed [WORD_W-1:0]  RST_ORIGIN_IM = 32'sd536870912;
  localparam logic [STEP_W-1:0]         RST_STEP_RE   = 31'd15339169;
  localparam logic [STEP_W-1:0]         RST_STEP_IM   = 31'd21474836;
  localparam logic signed [CONST_W-1:0] RST_C_RE      = 30'sd134217728;
  localparam logic signed [CONST_W-1:0] RST_C_IM      = 30'sd134217728;
  localparam logic [ITER_W-1:0]         RST_MAX_ITER  = 16'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE = 3'd0,
    REG_ORIGIN_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_C_RE      = 3'd4,
    REG_C_IM      = 3'd5,
    REG_MAX_ITER  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  origin_re;
    logic signed [WORD_W-1:0]  origin_im;
    logic [STEP_W-1:0]         step_re;
    logic [STEP_W-1:0]         step_im;
    logic signed [CONST_W-1:0] c_re;
    logic signed [CONST_W-1:0] c_im;
    logic [ITER_W-1:0]         max_iter;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] re;
    logic signed [WORD_W-1:0] im;
  } point_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_ctl_t;

  // Clamp a wide signed value to the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > WORD_MAX_W) begin
      r = WORD_MAX_W[WORD_W-1:0];
    end else if (v < WORD_MIN_W) begin
      r = WORD_MIN_W[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/jet_front.sv
// Front end: accepts a pixel and maps it to its complex start point.
// Depends on jet_pkg; pushes points into jet_queue.
`timescale 1ns / 1ps

module jet_front import jet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  accept,
  input  logic [COORD_BITS-1:0] col,
  input  logic [COORD_BITS-1:0] row,
  output logic                  pending,
  output q_wr_ctl_t             q_ctl,
  output point_t                q_data,
  input  logic                  q_full
);

  logic              f1_v_r, f1_v_nxt;
  logic [OFFS_W-1:0] off_re_r, off_im_r;
  logic signed [PROD_W-1:0] re_wide, im_wide;

  // Stage 1: column and row offsets; stage 2: add origin, clamp, push
  always_comb begin
    re_wide = PROD_W'($signed(cfg.origin_re)) + $signed(PROD_W'(off_re_r));
    im_wide = PROD_W'($signed(cfg.origin_im)) - $signed(PROD_W'(off_im_r));
    q_data.re = sat_word(re_wide);
    q_data.im = sat_word(im_wide);
    q_ctl.push = f1_v_r && !q_full;
    q_ctl.full = q_full;
    f1_v_nxt = f1_v_r;
    if (q_ctl.push) begin
      f1_v_nxt = 1'b0;
    end
    if (accept) begin
      f1_v_nxt = 1'b1;
    end
  end

  assign pending = f1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      off_re_r <= OFFS_W'(col) * OFFS_W'(cfg.step_re);
      off_im_r <= OFFS_W'(row) * OFFS_W'(cfg.step_im);
    end
  end

endmodule

### rtl/jet_queue.sv
// Short point queue between the front end and the iteration unit.
// Depends on jet_pkg.
`timescale 1ns / 1ps

module jet_queue import jet_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  point_t    wr_data,
  output logic      full,
  input  logic      pop,
  output point_t    rd_data,
  output logic      empty
);

  point_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  q_full_pop : assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> !push || $past(push) == 1'b0)
    else $error("queue written while full");
  q_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");
  q_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> !empty)
    else $error("queue count lost a push");

endmodule

### rtl/jet_iter.sv
// Back end: iterates z = z*z + c on one point and reports its escape count.
// Depends on jet_pkg; pops points from jet_queue.
`timescale 1ns / 1ps

module jet_iter import jet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  q_rd_ctl_t         q_in,
  input  point_t            q_data,
  output logic              pop,
  output logic              res_valid,
  output logic [ITER_W-1:0] res_count
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_CHK  = 3'b100
  } bstate_t;

  bstate_t                  state_r, state_nxt;
  logic signed [WORD_W-1:0] re_r, re_nxt, im_r, im_nxt;
  logic [ITER_W-1:0]        cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] rr_r, ii_r, ri_r;
  logic                     res_valid_r, res_valid_nxt;
  logic [ITER_W-1:0]        res_count_r, res_count_nxt;
  logic [PROD_W-1:0]        mag;
  logic signed [PROD_W-1:0] diff;
  logic signed [WORD_W-1:0] nre, nim;

  always_comb begin
    mag  = rr_r + ii_r;
    diff = rr_r - ii_r;
    // floor-drop the fraction bits, then add c
    nre  = sat_word((diff >>> FRAC_BITS) + PROD_W'($signed(cfg.c_re)));
    nim  = sat_word((ri_r >>> (FRAC_BITS - 1)) + PROD_W'($signed(cfg.c_im)));
  end

  always_comb begin
    state_nxt     = state_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    res_valid_nxt = 1'b0;
    res_count_nxt = res_count_r;
    case (state_r)
      B_IDLE: begin
        if (!q_in.empty) begin
          pop       = 1'b1;
          re_nxt    = q_data.re;
          im_nxt    = q_data.im;
          cnt_nxt   = ITER_W'(1);
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        if (cnt_r >= cfg.max_iter) begin
          res_valid_nxt = 1'b1;
          res_count_nxt = cnt_r;
          state_nxt     = B_IDLE;
        end else begin
          state_nxt = B_CHK;
        end
      end
      B_CHK: begin
        if (mag >= ESC_LIMIT) begin
          res_valid_nxt = 1'b1;
          res_count_nxt = cnt_r;
          state_nxt     = B_IDLE;
        end else begin
          re_nxt    = nre;
          im_nxt    = nim;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = B_MUL;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r        <= re_nxt;
    im_r        <= im_nxt;
    cnt_r       <= cnt_nxt;
    res_count_r <= res_count_nxt;
    if (state_r == B_MUL) begin
      rr_r <= re_r * re_r;
      ii_r <= im_r * im_r;
      ri_r <= re_r * im_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res_count = res_count_r;

  it_pop_starts : assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == B_MUL && cnt_r == ITER_W'(1))
    else $error("pop did not start an iteration run");
  it_res_source : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> state_r == B_IDLE)
    else $error("result raised outside the return to idle");
  it_chk_below : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CHK |-> cnt_r < cfg.max_iter)
    else $error("escape test entered at the iteration limit");
  it_res_bound : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && cfg.max_iter != '0 |-> res_count_r <= cfg.max_iter &&
      res_count_r != '0)
    else $error("escape count out of range");

endmodule

### rtl/julia_escape_time.sv
// Top level of the Julia escape-time pixel evaluator: configuration registers,
// front end, point queue and iteration unit. Depends on jet_pkg, jet_front,
// jet_queue and jet_iter.
`timescale 1ns / 1ps

//  channel  | ports                              | handshake
//  ---------+------------------------------------+------------------------------
//  pixel in | in_col, in_row                     | start & !busy accepts an item
//  result   | out_iteration_count                | out_valid strobe, one cycle
//  config   | cfg_index, cfg_data                | cfg_valid & cfg_ready writes
//
// The front end registers the column and row offsets, then adds the origin to
// form the start point; the iteration unit takes a point, then runs each
// iteration as a multiply step, then an escape test and update step. The
// iteration loop is what sets the rate. Reset is synchronous, active low, and
// loads the default view. Results cannot be stalled: each one shows for one
// cycle. Up to two points wait in the queue while the iteration unit works.

module julia_escape_time import jet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_col,
  input  logic [COORD_BITS-1:0] in_row,
  output logic                  out_valid,
  output logic [ITER_W-1:0]     out_iteration_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  logic      accept;
  logic      front_pending;
  q_wr_ctl_t q_wr;
  point_t    q_wr_data;
  point_t    q_rd_data;
  logic      q_full;
  logic      q_pop;
  q_rd_ctl_t q_rd;
  logic      q_empty;

  // Register writes are always taken; unknown indexes drop the data.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re <= RST_ORIGIN_RE;
      cfg_r.origin_im <= RST_ORIGIN_IM;
      cfg_r.step_re   <= RST_STEP_RE;
      cfg_r.step_im   <= RST_STEP_IM;
      cfg_r.c_re      <= RST_C_RE;
      cfg_r.c_im      <= RST_C_IM;
      cfg_r.max_iter  <= RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_RE: cfg_r.origin_re <= cfg_data[WORD_W-1:0];
        REG_ORIGIN_IM: cfg_r.origin_im <= cfg_data[WORD_W-1:0];
        REG_STEP_RE:   cfg_r.step_re   <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:   cfg_r.step_im   <= cfg_data[STEP_W-1:0];
        REG_C_RE:      cfg_r.c_re      <= cfg_data[CONST_W-1:0];
        REG_C_IM:      cfg_r.c_im      <= cfg_data[CONST_W-1:0];
        REG_MAX_ITER:  cfg_r.max_iter  <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold off new pixels while one is mid-front or the queue has no room.
  assign busy   = front_pending || q_full;
  assign accept = start && !busy;

  jet_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .col     (in_col),
    .row     (in_row),
    .pending (front_pending),
    .q_ctl   (q_wr),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  jet_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_wr.push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign q_rd.pop   = q_pop;
  assign q_rd.empty = q_empty;

  jet_iter u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_in      (q_rd),
    .q_data    (q_rd_data),
    .pop       (q_pop),
    .res_valid (out_valid),
    .res_count (out_iteration_count)
  );

  top_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("front end took a pixel without going busy");
  top_pop_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    q_rd.pop |-> !q_rd.empty)
    else $error("iteration unit took from an empty queue");
  top_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_wr.full)
    else $error("front end pushed into a full queue");

endmodule
